FILE: hdl/line_rasterizer_implicit_equation_defines.svh
// ---------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared assertion forms for the line rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_IMPLICIT_EQUATION_DEFINES_SVH
`define LINE_RASTERIZER_IMPLICIT_EQUATION_DEFINES_SVH

// condition holds in the same cycle
`define LRI_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lri assertion failed");

// condition holds in the next cycle
`define LRI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lri assertion failed");

`endif

FILE: hdl/lri_pkg.sv
// ---------------------------------------------------------------------------
// lri_pkg
// Types shared by the line rasterizer front and back ends.
// ---------------------------------------------------------------------------
package lri_pkg;

    localparam int FLAG_W = 3;

    typedef struct packed {
        logic x_major;
        logic fixed;   // divisor is zero: minor comes from the start point
        logic last;
    } job_flags_t;

endpackage

FILE: hdl/lri_in_if.sv
// ---------------------------------------------------------------------------
// lri_in_if
// Input channel: load or step beats.
// ---------------------------------------------------------------------------
interface lri_in_if #(parameter int CB = 12);
    logic          valid;
    logic          ready;
    logic          kind;
    logic [CB-1:0] x_start;
    logic [CB-1:0] y_start;
    logic [CB-1:0] x_end;
    logic [CB-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

FILE: hdl/lri_out_if.sv
// ---------------------------------------------------------------------------
// lri_out_if
// Output channel: one pixel per beat.
// ---------------------------------------------------------------------------
interface lri_out_if #(parameter int CB = 12);
    logic          valid;
    logic          ready;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

FILE: hdl/lri_front.sv
// ---------------------------------------------------------------------------
// lri_front
// Holds the line setup, walks the major axis and forms one division job
// per pixel.
// ---------------------------------------------------------------------------
module lri_front #(
    parameter int CB    = 12,
    parameter int NUM_W = 2*CB+2,
    parameter int JOB_W = 3 + 3*CB + NUM_W
) (
    input  logic             clk,
    input  logic             rst_n,
    lri_in_if.sink           src,
    input  logic             q_full,
    output logic             push,
    output logic [JOB_W-1:0] job
);

    logic signed [CB:0]      coef_r_reg, coef_r_next;
    logic signed [CB:0]      coef_s_reg, coef_s_next;
    logic signed [NUM_W-1:0] coef_t_reg, coef_t_next;
    logic                    x_major_reg, x_major_next;
    logic [CB-1:0]           major_pos_reg, major_pos_next;
    logic [CB-1:0]           major_stop_reg, major_stop_next;
    logic [CB-1:0]           fixed_minor_reg, fixed_minor_next;
    logic                    active_reg, active_next;

    logic                    accept;
    logic [CB-1:0]           dx, dy;
    logic signed [CB:0]      coef_mul;
    logic signed [NUM_W-1:0] prod, sum;
    logic [NUM_W-1:0]        num_abs;
    logic [CB-1:0]           den_abs;
    lri_pkg::job_flags_t     flags;

    assign src.ready = !q_full;
    assign accept    = src.valid && src.ready;
    assign push      = accept && src.kind && active_reg;

    assign dx = (src.x_end > src.x_start) ? src.x_end - src.x_start : src.x_start - src.x_end;
    assign dy = (src.y_end > src.y_start) ? src.y_end - src.y_start : src.y_start - src.y_end;

    // minor = -(c*pos + t) / d; the quotient is never negative on the line
    always_comb
    begin
        coef_mul = x_major_reg ? coef_r_reg : coef_s_reg;
        prod     = NUM_W'(coef_mul * $signed({1'b0, major_pos_reg}));
        sum      = prod + coef_t_reg;
        num_abs  = sum[NUM_W-1] ? NUM_W'(-sum) : NUM_W'(sum);
        if (x_major_reg)
            den_abs = coef_s_reg[CB] ? CB'(-coef_s_reg) : coef_s_reg[CB-1:0];
        else
            den_abs = coef_r_reg[CB] ? CB'(-coef_r_reg) : coef_r_reg[CB-1:0];
        flags.x_major = x_major_reg;
        flags.fixed   = (den_abs == '0);
        flags.last    = (major_pos_reg >= major_stop_reg);
    end

    assign job = {flags, major_pos_reg, fixed_minor_reg, num_abs, den_abs};

    always_comb
    begin
        coef_r_next      = coef_r_reg;
        coef_s_next      = coef_s_reg;
        coef_t_next      = coef_t_reg;
        x_major_next     = x_major_reg;
        major_pos_next   = major_pos_reg;
        major_stop_next  = major_stop_reg;
        fixed_minor_next = fixed_minor_reg;
        active_next      = active_reg;
        if (accept && !src.kind)
        begin
            coef_r_next  = $signed({1'b0, src.y_end}) - $signed({1'b0, src.y_start});
            coef_s_next  = $signed({1'b0, src.x_start}) - $signed({1'b0, src.x_end});
            coef_t_next  = $signed(NUM_W'(src.x_end * src.y_start))
                         - $signed(NUM_W'(src.x_start * src.y_end));
            x_major_next = dx > dy;
            if (dx > dy)
            begin
                major_pos_next   = (src.x_start < src.x_end) ? src.x_start : src.x_end;
                major_stop_next  = (src.x_start < src.x_end) ? src.x_end : src.x_start;
                fixed_minor_next = src.y_start;
            end
            else
            begin
                major_pos_next   = (src.y_start < src.y_end) ? src.y_start : src.y_end;
                major_stop_next  = (src.y_start < src.y_end) ? src.y_end : src.y_start;
                fixed_minor_next = src.x_start;
            end
            active_next = 1'b1;
        end
        else if (push)
        begin
            if (flags.last)
                active_next = 1'b0;
            else
                major_pos_next = major_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_r_reg      <= '0;
            coef_s_reg      <= '0;
            coef_t_reg      <= '0;
            x_major_reg     <= 1'b0;
            major_pos_reg   <= '0;
            major_stop_reg  <= '0;
            fixed_minor_reg <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            coef_r_reg      <= coef_r_next;
            coef_s_reg      <= coef_s_next;
            coef_t_reg      <= coef_t_next;
            x_major_reg     <= x_major_next;
            major_pos_reg   <= major_pos_next;
            major_stop_reg  <= major_stop_next;
            fixed_minor_reg <= fixed_minor_next;
            active_reg      <= active_next;
        end
    end

endmodule

FILE: hdl/lri_queue.sv
// ---------------------------------------------------------------------------
// lri_queue
// Two-entry job queue between the front and back ends.
// ---------------------------------------------------------------------------
module lri_queue #(
    parameter int JOB_W = 51
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [JOB_W-1:0] wr_job,
    input  logic             pop,
    output logic [JOB_W-1:0] rd_job,
    output logic             full,
    output logic             empty
);

    logic [JOB_W-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/lri_back.sv
// ---------------------------------------------------------------------------
// lri_back
// Rounded division of one job, one quotient bit per cycle, into the
// output register; a zero-divisor job skips the division.
// ---------------------------------------------------------------------------
`include "line_rasterizer_implicit_equation_defines.svh"

module lri_back #(
    parameter int CB    = 12,
    parameter int NUM_W = 2*CB+2,
    parameter int JOB_W = 3 + 3*CB + NUM_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [JOB_W-1:0] job,
    input  logic             q_empty,
    output logic             pop,
    lri_out_if.source        dst
);

    localparam int CNT_W = $clog2(CB+1);
    localparam int REM_W = NUM_W + 1;

    lri_pkg::job_flags_t flags_in;
    logic [CB-1:0]       pos_in, fmin_in, den_in;
    logic [NUM_W-1:0]    num_in;

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    dsh_reg, dsh_next;
    logic [CB-1:0]       q_reg, q_next;
    logic [CB-1:0]       pos_reg, pos_next;
    lri_pkg::job_flags_t flags_reg, flags_next;
    logic                ovalid_reg, ovalid_next;
    logic [CB-1:0]       px_reg, px_next, py_reg, py_next;
    logic                olast_reg, olast_next;
    logic                slot_free, finish;

    assign {flags_in, pos_in, fmin_in, num_in, den_in} = job;

    assign slot_free = !ovalid_reg || dst.ready;
    assign finish    = busy_reg && (cnt_reg == '0) && slot_free;
    assign pop       = !busy_reg && !q_empty;

    assign dst.valid   = ovalid_reg;
    assign dst.pixel_x = px_reg;
    assign dst.pixel_y = py_reg;
    assign dst.last    = olast_reg;

    // q = (2n + d) / (2d): restoring division, MSB first
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        q_next      = q_reg;
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        ovalid_next = ovalid_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        olast_next  = olast_reg;

        if (ovalid_reg && dst.ready)
            ovalid_next = 1'b0;

        if (pop)
        begin
            busy_next  = 1'b1;
            pos_next   = pos_in;
            flags_next = flags_in;
            rem_next   = {num_in, 1'b0} + REM_W'(den_in);
            dsh_next   = REM_W'(den_in) << CB;
            q_next     = fmin_in;
            cnt_next   = flags_in.fixed ? '0 : CNT_W'(CB);
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[CB-2:0], 1'b1};
            end
            else
                q_next = {q_reg[CB-2:0], 1'b0};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
        else if (finish)
        begin
            busy_next   = 1'b0;
            ovalid_next = 1'b1;
            px_next     = flags_reg.x_major ? pos_reg : q_reg;
            py_next     = flags_reg.x_major ? q_reg : pos_reg;
            olast_next  = flags_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        pos_reg   <= pos_next;
        flags_reg <= flags_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    `LRI_ASSERT_NEXT(a_iter_stays_busy, clk, rst_n, busy_reg && cnt_reg != '0, busy_reg)
    `LRI_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(CB))
    `LRI_ASSERT_NEXT(a_finish_shows, clk, rst_n, finish, ovalid_reg && !busy_reg)
    `LRI_ASSERT_NOW(a_pop_idle, clk, rst_n, pop, !busy_reg && !q_empty)

endmodule

FILE: hdl/line_rasterizer_implicit_equation.sv
// ---------------------------------------------------------------------------
// line_rasterizer_implicit_equation
// Line rasterizer on r*x + s*y + t = 0 with a rounded exact minor coordinate.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                  | beat
//  src     | in  | kind, x_start, y_start, x_end, y_end     | load or step
//  dst     | out | pixel_x, pixel_y, last                   | one pixel
//
//  A load is registered in the front end and gives no pixel.
//  A step pixel goes through the one-bit-per-cycle divider in the back end;
//  a zero-divisor pixel skips the divider.
//  A two-entry queue lets the front end run ahead of the divider until it is full.
//  rst_n is asynchronous; control state clears, no line is loaded.
//  A stalled dst holds the pixel register and then the divider.
// ---------------------------------------------------------------------------
module line_rasterizer_implicit_equation #(
    parameter int COORD_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    lri_in_if.sink    src,
    lri_out_if.source dst
);

    localparam int NUM_W = 2*COORD_BITS + 2;
    localparam int JOB_W = lri_pkg::FLAG_W + 3*COORD_BITS + NUM_W;

    logic             push, pop, q_full, q_empty;
    logic [JOB_W-1:0] wr_job, rd_job;

    lri_front #(.CB(COORD_BITS), .NUM_W(NUM_W), .JOB_W(JOB_W)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .q_full (q_full),
        .push   (push),
        .job    (wr_job)
    );

    lri_queue #(.JOB_W(JOB_W)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    lri_back #(.CB(COORD_BITS), .NUM_W(NUM_W), .JOB_W(JOB_W)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (rd_job),
        .q_empty (q_empty),
        .pop     (pop),
        .dst     (dst)
    );

endmodule
